// File: src/square_matrix_multiply_top_macros.svh
// Assertion macros shared by the matrix multiply RTL.
`ifndef SQUARE_MATRIX_MULTIPLY_TOP_MACROS_SVH
`define SQUARE_MATRIX_MULTIPLY_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, disabled in reset.
`define SMM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smm assertion failed");
// Next-cycle implication, sampled on clk, disabled in reset.
`define SMM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smm assertion failed");
`else
`define SMM_ASSERT_NOW(label, ante, cons)
`define SMM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: src/smm_pkg.sv
// Shared types and constants of the matrix multiply block.
package smm_pkg;

    localparam int IDX_W      = 4;
    localparam int SIZE_W     = 5;
    localparam int VAL_W      = 32;
    localparam int PROD_W     = 64;
    localparam int SIZE_RESET = 16;

    // Request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Per-cycle command into the MAC, issued alongside the memory reads
    typedef struct packed {
        logic vld;    // a term is being read this cycle
        logic first;  // first term of a dot product
        logic last;   // last term of a dot product
        logic clr;    // empty sum: zero result, strobe next cycle
    } mac_ctl_t;

    // MAC status back to the controller
    typedef struct packed {
        logic finishing;  // last term accumulates at this edge
    } mac_sts_t;

endpackage

// File: src/smm_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module smm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/smm_mac.sv
// Pipelined multiply-accumulate unit: align, multiply, accumulate.
module smm_mac #(
    parameter int ELEM_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  smm_pkg::mac_ctl_t       ctl,
    input  logic [ELEM_WIDTH-1:0]   a,
    input  logic [ELEM_WIDTH-1:0]   b,
    output logic [smm_pkg::PROD_W-1:0] acc,
    output logic                    done,
    output smm_pkg::mac_sts_t       sts
);
    import smm_pkg::*;

    localparam int MW = 2 * ELEM_WIDTH;

    logic          s1_vld_reg, s1_first_reg, s1_last_reg;
    logic          s2_vld_reg, s2_first_reg, s2_last_reg;
    logic [MW-1:0] prod_reg;
    logic [PROD_W-1:0] acc_reg;
    logic          done_reg;

    // Control flags travel with the data: s1 matches RAM output, s2 the product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg   <= 1'b0;
            s1_first_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s2_first_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_vld_reg   <= ctl.vld;
            s1_first_reg <= ctl.first;
            s1_last_reg  <= ctl.last;
            s2_vld_reg   <= s1_vld_reg;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            done_reg     <= (s2_vld_reg && s2_last_reg) || ctl.clr;
        end
    end

    // Multiply stage
    always_ff @(posedge clk)
    begin
        if (s1_vld_reg)
        begin
            prod_reg <= MW'(a) * MW'(b);
        end
    end

    // Accumulate stage, restarts at the first term; wraps modulo 2^64
    always_ff @(posedge clk)
    begin
        if (ctl.clr)
        begin
            acc_reg <= '0;
        end
        else if (s2_vld_reg)
        begin
            acc_reg <= (s2_first_reg ? '0 : acc_reg) + PROD_W'(prod_reg);
        end
    end

    assign acc           = acc_reg;
    assign done          = done_reg;
    assign sts.finishing = s2_vld_reg && s2_last_reg;

endmodule

// File: src/square_matrix_multiply_top.sv
// Top level of the square matrix multiply block: controller, stores and MAC.
//
// Usage: an item is transferred at a rising edge with start high and busy low.
// req_type REQ_LOAD writes left_value and right_value at (row_index, col_index)
// of the two source matrices in that same edge; the next item may follow in
// the next cycle. req_type REQ_READ computes the dot product of the requested
// row of the left matrix with the requested column of the right matrix over
// n = min(size_in_use, MAX_DIM) terms, wrapped to 64 bits.
// The result is on out_row, out_col and product_value for exactly one cycle,
// marked by done; the receiver cannot stall it.
// Timing: done is registered together with the sum of the last term (the next
// cycle after the transferring edge when n is zero); busy stays high until done
// is high. The single MAC takes one term per cycle, read from the two element
// memories through one read port each. Configuration: cfg_write with cfg_data
// sets size_in_use, only while idle; the user must keep to this, the block does
// not enforce it. Reset: size_in_use returns to 16, the controller goes idle;
// the element memories keep no reset and must be loaded before they are read.
`include "square_matrix_multiply_top_macros.svh"

module square_matrix_multiply_top #(
    parameter int MAX_DIM    = 16,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         req_type,
    input  logic [smm_pkg::IDX_W-1:0]    row_index,
    input  logic [smm_pkg::IDX_W-1:0]    col_index,
    input  logic [smm_pkg::VAL_W-1:0]    left_value,
    input  logic [smm_pkg::VAL_W-1:0]    right_value,
    input  logic                         cfg_write,
    input  logic [smm_pkg::SIZE_W-1:0]   cfg_data,
    output logic                         done,
    output logic [smm_pkg::IDX_W-1:0]    out_row,
    output logic [smm_pkg::IDX_W-1:0]    out_col,
    output logic [smm_pkg::PROD_W-1:0]   product_value
);
    import smm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int NW    = $clog2(MAX_DIM + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT
    } state_t;

    // Index reduced modulo MAX_DIM, as a small constant table
    function automatic logic [KW-1:0] dim_mod(input logic [IDX_W-1:0] v);
        logic [KW-1:0] r;
        r = '0;
        for (int i = 0; i < 2 ** IDX_W; i++)
        begin
            if (v == IDX_W'(i))
            begin
                r = KW'(i % MAX_DIM);
            end
        end
        return r;
    endfunction

    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] size_reg;
    logic [NW-1:0]     n_reg, n_next;
    logic [NW-1:0]     k_reg, k_next;
    logic [AW-1:0]     la_reg, la_next;
    logic [AW-1:0]     ra_reg, ra_next;
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [IDX_W-1:0]  col_reg, col_next;

    logic              accept;
    logic              load_acc;
    logic              read_acc;
    logic [NW-1:0]     n_sel;
    logic [KW-1:0]     row_m;
    logic [KW-1:0]     col_m;
    logic [AW-1:0]     waddr;
    logic              last_term;
    mac_ctl_t          ctl;
    mac_sts_t          sts;
    logic [ELEM_WIDTH-1:0] left_q;
    logic [ELEM_WIDTH-1:0] right_q;

    // Transfer decode
    assign accept   = start && !busy;
    assign load_acc = accept && (req_type == REQ_LOAD);
    assign read_acc = accept && (req_type == REQ_READ);

    // Terms in use, saturated to MAX_DIM
    assign n_sel = (int'(size_reg) > MAX_DIM) ? NW'(MAX_DIM) : NW'(size_reg);

    // Address generation
    assign row_m     = dim_mod(row_index);
    assign col_m     = dim_mod(col_index);
    assign waddr     = AW'(int'(row_m) * MAX_DIM + int'(col_m));
    assign last_term = (k_reg == n_reg - NW'(1));

    // MAC command for the read issued this cycle
    always_comb
    begin
        ctl.vld   = (state_reg == S_RUN);
        ctl.first = (state_reg == S_RUN) && (k_reg == '0);
        ctl.last  = (state_reg == S_RUN) && last_term;
        ctl.clr   = read_acc && (n_sel == '0);
    end

    // Controller next state
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        la_next    = la_reg;
        ra_next    = ra_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (read_acc)
                begin
                    row_next = row_index;
                    col_next = col_index;
                    n_next   = n_sel;
                    k_next   = '0;
                    la_next  = AW'(int'(row_m) * MAX_DIM);
                    ra_next  = AW'(col_m);
                    if (n_sel != '0)
                    begin
                        state_next = S_RUN;
                    end
                end
            end
            S_RUN:
            begin
                k_next  = k_reg + NW'(1);
                la_next = la_reg + AW'(1);
                ra_next = ra_reg + AW'(MAX_DIM);
                if (last_term)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (sts.finishing)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered request fields
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= '0;
            k_reg     <= '0;
            la_reg    <= '0;
            ra_reg    <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            la_reg    <= la_next;
            ra_reg    <= ra_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    // Size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_W'(SIZE_RESET);
        end
        else if (cfg_write)
        begin
            size_reg <= cfg_data;
        end
    end

    // Element stores; writes only while idle, reads only while running
    smm_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_left_ram (
        .clk   (clk),
        .we    (load_acc),
        .waddr (waddr),
        .wdata (left_value[ELEM_WIDTH-1:0]),
        .re    (ctl.vld),
        .raddr (la_reg),
        .rdata (left_q)
    );

    smm_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_right_ram (
        .clk   (clk),
        .we    (load_acc),
        .waddr (waddr),
        .wdata (right_value[ELEM_WIDTH-1:0]),
        .re    (ctl.vld),
        .raddr (ra_reg),
        .rdata (right_q)
    );

    smm_mac #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .a     (left_q),
        .b     (right_q),
        .acc   (product_value),
        .done  (done),
        .sts   (sts)
    );

    assign busy    = (state_reg != S_IDLE);
    assign out_row = row_reg;
    assign out_col = col_reg;

    // Checks
    `SMM_ASSERT_NEXT(a_finish_strobes, sts.finishing, done)
    `SMM_ASSERT_NEXT(a_read_holds_busy, read_acc && (n_sel != '0), busy)
    `SMM_ASSERT_NOW(a_term_in_range, state_reg == S_RUN, k_reg < n_reg)
    `SMM_ASSERT_NEXT(a_load_no_result, load_acc, !done)

endmodule

// File: tb/sv/tb_square_matrix_multiply_top.sv
// Self-checking testbench for the square matrix multiply top level.
`timescale 1ns / 1ps

module tb_square_matrix_multiply_top;
    import smm_pkg::*;

    localparam int          MAX_DIM     = 16;
    localparam int          DRAIN_TAIL  = MAX_DIM + 4;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int          PHASE_ITEMS = 45;
    localparam int          NUM_PHASES  = 10;

    // Directed step kinds
    localparam logic [1:0] STEP_CFG  = 2'd0;
    localparam logic [1:0] STEP_LOAD = 2'd1;
    localparam logic [1:0] STEP_READ = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SIZE_W-1:0] size;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [VAL_W-1:0]  lval;
        logic [VAL_W-1:0]  rval;
        logic              known;
        logic [PROD_W-1:0] want;
    } dir_step_t;

    typedef struct packed {
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [PROD_W-1:0] value;
    } product_exp_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                req_type;
    logic [IDX_W-1:0]    row_index;
    logic [IDX_W-1:0]    col_index;
    logic [VAL_W-1:0]    left_value;
    logic [VAL_W-1:0]    right_value;
    logic                cfg_write;
    logic [SIZE_W-1:0]   cfg_data;
    logic                done;
    logic [IDX_W-1:0]    out_row;
    logic [IDX_W-1:0]    out_col;
    logic [PROD_W-1:0]   product_value;

    // Predictor state: element copies, written flags, size in use
    logic [VAL_W-1:0]  left_mat  [MAX_DIM][MAX_DIM];
    logic [VAL_W-1:0]  right_mat [MAX_DIM][MAX_DIM];
    bit                elem_written [MAX_DIM][MAX_DIM];
    logic [SIZE_W-1:0] size_now;

    product_exp_t pending_products[$];
    dir_step_t    dir_steps[$];
    int           err_count;
    int           item_count;
    int unsigned  cycle_count;
    bit           burst_mode;

    square_matrix_multiply_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .row_index     (row_index),
        .col_index     (col_index),
        .left_value    (left_value),
        .right_value   (right_value),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .done          (done),
        .out_row       (out_row),
        .out_col       (out_col),
        .product_value (product_value)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Terms actually summed: size saturates at the store dimension
    function automatic int terms_in_use();
        return (size_now > MAX_DIM) ? MAX_DIM : int'(size_now);
    endfunction

    function automatic logic [PROD_W-1:0] predict_product(input logic [IDX_W-1:0] r,
                                                          input logic [IDX_W-1:0] c);
        logic [PROD_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < terms_in_use(); k++)
            acc = acc + {32'd0, left_mat[r][k]} * {32'd0, right_mat[k][c]};
        return acc;
    endfunction

    // A read is legal only when every element it touches was loaded
    function automatic bit read_is_loaded(input logic [IDX_W-1:0] r,
                                          input logic [IDX_W-1:0] c);
        for (int k = 0; k < terms_in_use(); k++)
            if (!elem_written[r][k] || !elem_written[k][c])
                return 1'b0;
        return 1'b1;
    endfunction

    // Element values biased toward the extremes
    function automatic logic [VAL_W-1:0] rand_elem();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic dir_step_t s_cfg(input logic [SIZE_W-1:0] sz);
        return '{kind: STEP_CFG, size: sz, default: '0};
    endfunction

    function automatic dir_step_t s_load(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
                                         input logic [VAL_W-1:0] lv, input logic [VAL_W-1:0] rv);
        return '{kind: STEP_LOAD, row: r, col: c, lval: lv, rval: rv, default: '0};
    endfunction

    function automatic dir_step_t s_read(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
                                         input logic known, input logic [PROD_W-1:0] want);
        return '{kind: STEP_READ, row: r, col: c, known: known, want: want, default: '0};
    endfunction

    task automatic note_error(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // One item transfer; start stays high so a back-to-back item needs no toggle
    task automatic send_item(input logic rq, input logic [IDX_W-1:0] r,
                             input logic [IDX_W-1:0] c, input logic [VAL_W-1:0] lv,
                             input logic [VAL_W-1:0] rv, input logic known,
                             input logic [PROD_W-1:0] want);
        int gap;
        product_exp_t exp_item;
        gap = burst_mode ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        req_type    <= rq;
        row_index   <= r;
        col_index   <= c;
        left_value  <= lv;
        right_value <= rv;
        do
            @(posedge clk);
        while (busy);
        item_count++;
        if (rq == REQ_LOAD)
        begin
            left_mat[r][c]     = lv;
            right_mat[r][c]    = rv;
            elem_written[r][c] = 1'b1;
        end
        else
        begin
            exp_item.row   = r;
            exp_item.col   = c;
            exp_item.value = known ? want : predict_product(r, c);
            pending_products.push_back(exp_item);
        end
    endtask

    // Hold off until every product has come back, then let the block settle
    task automatic wait_products_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending_products.size() != 0 || busy)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] sz);
        wait_products_drained();
        cfg_write <= 1'b1;
        cfg_data  <= sz;
        @(posedge clk);
        cfg_write <= 1'b0;
        size_now = sz;
    endtask

    // Load what one product needs (plus some rewrites), then read it
    task automatic run_product_sequence();
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] c;
        logic [IDX_W-1:0] kk;
        r = IDX_W'($urandom_range(0, MAX_DIM - 1));
        c = IDX_W'($urandom_range(0, MAX_DIM - 1));
        for (int k = 0; k < terms_in_use(); k++)
        begin
            kk = k[IDX_W-1:0];
            if (!elem_written[r][kk] || $urandom_range(0, 5) == 0)
                send_item(REQ_LOAD, r, kk, rand_elem(), rand_elem(), 1'b0, '0);
            if (!elem_written[kk][c] || $urandom_range(0, 5) == 0)
                send_item(REQ_LOAD, kk, c, rand_elem(), rand_elem(), 1'b0, '0);
        end
        send_item(REQ_READ, r, c, $urandom, $urandom, 1'b0, '0);
    endtask

    // Single stray item: a read when a coin toss allows and it is legal, else a load
    task automatic run_noise_item();
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] c;
        r = IDX_W'($urandom_range(0, MAX_DIM - 1));
        c = IDX_W'($urandom_range(0, MAX_DIM - 1));
        if ($urandom_range(0, 1) == 1 && read_is_loaded(r, c))
            send_item(REQ_READ, r, c, $urandom, $urandom, 1'b0, '0);
        else
            send_item(REQ_LOAD, r, c, rand_elem(), rand_elem(), 1'b0, '0);
    endtask

    function automatic logic [SIZE_W-1:0] phase_size(input int p);
        case (p)
            0: return 5'd16;
            1: return 5'd31;
            2: return 5'd1;
            3: return 5'd16;
            4: return 5'd0;
            5: return 5'd17;
            6: return 5'd8;
            7: return 5'd2;
            8: return 5'd16;
            default: return SIZE_W'($urandom_range(0, 31));
        endcase
    endfunction

    // Result check against the oldest expected product
    always @(posedge clk)
    begin : product_check
        product_exp_t want_item;
        if (rst_n && done)
        begin
            if (pending_products.size() == 0)
                note_error($sformatf("unexpected result row=%0d col=%0d value=%h",
                                     out_row, out_col, product_value));
            else
            begin
                want_item = pending_products.pop_front();
                if (out_row !== want_item.row)
                    note_error($sformatf("out_row exp %0d got %0d", want_item.row, out_row));
                if (out_col !== want_item.col)
                    note_error($sformatf("out_col exp %0d got %0d", want_item.col, out_col));
                if (product_value !== want_item.value)
                    note_error($sformatf("product_value (%0d,%0d) exp %h got %h",
                                         want_item.row, want_item.col,
                                         want_item.value, product_value));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_square_matrix_multiply_top: done, errors");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        dir_step_t    st;
        int           phase_end;
        err_count   = 0;
        item_count  = 0;
        cycle_count = 0;
        burst_mode  = 1'b0;
        size_now    = SIZE_W'(SIZE_RESET);
        rst_n       <= 1'b0;
        start       <= 1'b0;
        req_type    <= REQ_LOAD;
        row_index   <= '0;
        col_index   <= '0;
        left_value  <= '0;
        right_value <= '0;
        cfg_write   <= 1'b0;
        cfg_data    <= '0;

        // Directed steps: extreme values, empty sum, extreme indexes
        dir_steps.push_back(s_cfg(5'd1));
        dir_steps.push_back(s_load(4'd0, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        dir_steps.push_back(s_read(4'd0, 4'd0, 1'b1, 64'hFFFF_FFFE_0000_0001));
        dir_steps.push_back(s_load(4'd0, 4'd0, 32'h0, 32'h0));
        dir_steps.push_back(s_read(4'd0, 4'd0, 1'b1, 64'h0));
        dir_steps.push_back(s_cfg(5'd0));
        dir_steps.push_back(s_read(4'd15, 4'd15, 1'b1, 64'h0));
        dir_steps.push_back(s_read(4'd7, 4'd9, 1'b1, 64'h0));
        dir_steps.push_back(s_cfg(5'd2));
        dir_steps.push_back(s_load(4'd0, 4'd1, 32'd3, 32'd5));
        dir_steps.push_back(s_load(4'd1, 4'd1, 32'd7, 32'd11));
        dir_steps.push_back(s_load(4'd0, 4'd0, 32'd2, 32'd13));
        dir_steps.push_back(s_load(4'd1, 4'd0, 32'd17, 32'd19));
        dir_steps.push_back(s_read(4'd0, 4'd1, 1'b0, '0));
        dir_steps.push_back(s_read(4'd1, 4'd0, 1'b0, '0));
        dir_steps.push_back(s_read(4'd1, 4'd1, 1'b0, '0));
        dir_steps.push_back(s_cfg(5'd1));
        dir_steps.push_back(s_load(4'd15, 4'd0, 32'hFFFF_FFFF, 32'd1));
        dir_steps.push_back(s_load(4'd0, 4'd15, 32'd2, 32'hFFFF_FFFF));
        dir_steps.push_back(s_read(4'd15, 4'd15, 1'b1, 64'hFFFF_FFFE_0000_0001));
        dir_steps.push_back(s_read(4'd0, 4'd15, 1'b0, '0));
        dir_steps.push_back(s_read(4'd15, 4'd0, 1'b0, '0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_steps[i])
        begin
            st = dir_steps[i];
            case (st.kind)
                STEP_CFG:  write_size(st.size);
                STEP_LOAD: send_item(REQ_LOAD, st.row, st.col, st.lval, st.rval, 1'b0, '0);
                default:   send_item(REQ_READ, st.row, st.col, $urandom, $urandom,
                                     st.known, st.want);
            endcase
        end

        // Random phases, each under its own size setting
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_size(phase_size(p));
            burst_mode = (p % 3 == 1);
            phase_end  = item_count + PHASE_ITEMS;
            while (item_count < phase_end)
            begin
                if ($urandom_range(0, 29) == 0)
                    wait_products_drained();
                if ($urandom_range(0, 3) == 0)
                    run_noise_item();
                else
                    run_product_sequence();
            end
        end

        wait_products_drained();
        if (err_count == 0)
            $display("tb_square_matrix_multiply_top: done, clean");
        else
            $display("tb_square_matrix_multiply_top: done, errors");
        $finish;
    end

endmodule

// File: square_matrix_multiply_top.f
+incdir+src
src/smm_pkg.sv
src/smm_ram.sv
src/smm_mac.sv
src/square_matrix_multiply_top.sv
tb/sv/tb_square_matrix_multiply_top.sv
